### design/pigeonhole_sorter_assert.svh
// ----------------------------------------------------------------------------
// Pigeonhole sorter assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef PIGEONHOLE_SORTER_ASSERT_SVH
`define PIGEONHOLE_SORTER_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PHS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PHS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/phs_pkg.sv
// ----------------------------------------------------------------------------
// Pigeonhole sorter package
// Shared constants, register indexes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package phs_pkg;

	localparam int PHS_HOLES     = 256;
	localparam int PHS_MAX_ITEMS = 64;
	localparam int VAL_W         = 16;
	localparam int CNT_W         = 7;
	localparam int IDX_W         = 1;

	localparam logic [IDX_W-1:0] REG_MIN_VALUE = 1'b0;
	localparam logic [IDX_W-1:0] REG_MAX_VALUE = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_INC,
		ST_WALK_RD,
		ST_WALK_CHK,
		ST_EMIT,
		ST_EMPTY
	} phs_state_t;

	typedef struct packed {
		logic idle;
		logic accept;
		logic inc;
		logic walk_start;
		logic walk_rd;
		logic walk_chk;
		logic clear_step;
		logic hole_next;
		logic emit;
		logic empty;
		logic finish;
	} phs_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic item_last;
		logic none_kept;
		logic zero_count;
		logic hole_end;
		logic run_done;
		logic out_free;
	} phs_status_t;

endpackage

### design/phs_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module phs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### design/phs_ctrl.sv
// ----------------------------------------------------------------------------
// Pigeonhole sorter controller
// Sequences the clearing pass, count updates and the ascending hole walk.
// ----------------------------------------------------------------------------
module phs_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  phs_pkg::phs_status_t status,
	output phs_pkg::phs_cmd_t    cmd
);

	import phs_pkg::*;

	phs_state_t state_q;
	phs_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (status.clear_done) state_nxt = ST_IDLE;
			end
			ST_IDLE: begin
				if (in_valid) state_nxt = ST_INC;
			end
			ST_INC: begin
				priority if (!status.item_last) state_nxt = ST_IDLE;
				else if (status.none_kept)      state_nxt = ST_EMPTY;
				else                            state_nxt = ST_WALK_RD;
			end
			ST_WALK_RD: begin
				state_nxt = ST_WALK_CHK;
			end
			ST_WALK_CHK: begin
				state_nxt = status.zero_count ? ST_WALK_RD : ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					priority if (status.run_done) state_nxt = ST_IDLE;
					else if (status.hole_end)     state_nxt = ST_WALK_RD;
					else                          state_nxt = ST_EMIT;
				end
			end
			ST_EMPTY: begin
				if (status.out_free) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
			end
			ST_IDLE: begin
				cmd.idle   = 1'b1;
				cmd.accept = in_valid;
			end
			ST_INC: begin
				cmd.inc        = 1'b1;
				cmd.walk_start = status.item_last && !status.none_kept;
			end
			ST_WALK_RD: begin
				cmd.walk_rd = 1'b1;
			end
			ST_WALK_CHK: begin
				cmd.walk_chk  = 1'b1;
				cmd.hole_next = status.zero_count;
			end
			ST_EMIT: begin
				cmd.emit      = status.out_free;
				cmd.finish    = status.out_free && status.run_done;
				cmd.hole_next = status.out_free && !status.run_done && status.hole_end;
			end
			ST_EMPTY: begin
				cmd.empty  = status.out_free;
				cmd.finish = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

### design/phs_dp.sv
// ----------------------------------------------------------------------------
// Pigeonhole sorter datapath
// Range check, hole count memory, walk counters and the output register.
// ----------------------------------------------------------------------------
module phs_dp #(
	parameter int HOLES     = phs_pkg::PHS_HOLES,
	parameter int MAX_ITEMS = phs_pkg::PHS_MAX_ITEMS
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  phs_pkg::phs_cmd_t                   cmd,
	output phs_pkg::phs_status_t                status,
	input  logic                                cfg_we,
	input  logic [phs_pkg::IDX_W-1:0]           cfg_index,
	input  logic [phs_pkg::VAL_W-1:0]           cfg_data,
	input  logic signed [phs_pkg::VAL_W-1:0]    value,
	input  logic                                is_last,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [phs_pkg::VAL_W-1:0]    sorted_value,
	output logic                                last_of_run,
	output logic                                is_empty,
	output logic                                had_drop
);

	import phs_pkg::*;

	localparam int                AW        = $clog2(HOLES);
	localparam logic [VAL_W:0]    HOLES_LIM = (VAL_W+1)'(HOLES);
	localparam logic [AW-1:0]     HOLE_LAST = AW'(HOLES - 1);
	localparam logic [CNT_W-1:0]  ITEM_LIM  = CNT_W'(MAX_ITEMS);

	logic signed [VAL_W-1:0] min_q;
	logic signed [VAL_W-1:0] max_q;
	logic [CNT_W-1:0]        kept_q;
	logic                    drop_q;
	logic [AW-1:0]           hole_q;
	logic [AW-1:0]           idx_q;
	logic                    keep_q;
	logic                    last_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [CNT_W-1:0]        sent_q;
	logic                    out_valid_q;
	logic [VAL_W-1:0]        sorted_q;
	logic                    last_out_q;
	logic                    empty_q;
	logic                    drop_out_q;

	logic [VAL_W:0]   diff;
	logic             keep;
	logic             out_free;
	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [CNT_W-1:0] ram_wdata;
	logic [AW-1:0]    ram_raddr;
	logic [CNT_W-1:0] ram_rdata;

	// Hole index of the incoming value; nonnegative whenever the value is in range.
	assign diff = {value[VAL_W-1], value} - {min_q[VAL_W-1], min_q};
	assign keep = (value >= min_q) && (value <= max_q) && (diff < HOLES_LIM)
		&& (kept_q < ITEM_LIM);

	assign out_free = !out_valid_q || !out_stall;

	assign ram_raddr = cmd.walk_rd ? hole_q : diff[AW-1:0];
	assign ram_we    = cmd.clear_step || cmd.walk_chk || (cmd.inc && keep_q);
	assign ram_waddr = cmd.inc ? idx_q : hole_q;
	assign ram_wdata = cmd.inc ? CNT_W'(ram_rdata + 1'b1) : '0;

	phs_ram #(
		.WIDTH (CNT_W),
		.DEPTH (HOLES)
	) u_counts (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q       <= '0;
			max_q       <= VAL_W'(255);
			kept_q      <= '0;
			drop_q      <= 1'b0;
			hole_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MIN_VALUE: min_q <= cfg_data;
					REG_MAX_VALUE: max_q <= cfg_data;
					default:       ;
				endcase
			end

			if (cmd.finish) begin
				kept_q <= '0;
				drop_q <= 1'b0;
			end else if (cmd.accept) begin
				if (keep) kept_q <= CNT_W'(kept_q + 1'b1);
				else      drop_q <= 1'b1;
			end

			if (cmd.walk_start) begin
				hole_q <= '0;
			end else if (cmd.clear_step || cmd.hole_next) begin
				hole_q <= AW'(hole_q + 1'b1);
			end

			if (cmd.emit || cmd.empty) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			idx_q  <= diff[AW-1:0];
			keep_q <= keep;
			last_q <= is_last;
		end
		if (cmd.walk_start) begin
			sent_q <= '0;
		end else if (cmd.emit) begin
			sent_q <= CNT_W'(sent_q + 1'b1);
		end
		if (cmd.walk_chk) begin
			cnt_q <= ram_rdata;
		end else if (cmd.emit) begin
			cnt_q <= CNT_W'(cnt_q - 1'b1);
		end
		if (cmd.emit) begin
			sorted_q   <= VAL_W'(min_q + VAL_W'(hole_q));
			last_out_q <= status.run_done;
			empty_q    <= 1'b0;
			drop_out_q <= drop_q;
		end else if (cmd.empty) begin
			sorted_q   <= '0;
			last_out_q <= 1'b1;
			empty_q    <= 1'b1;
			drop_out_q <= drop_q;
		end
	end

	assign status.clear_done = (hole_q == HOLE_LAST);
	assign status.item_last  = last_q;
	assign status.none_kept  = (kept_q == '0);
	assign status.zero_count = (ram_rdata == '0);
	assign status.hole_end   = (cnt_q == CNT_W'(1));
	assign status.run_done   = (CNT_W'(sent_q + 1'b1) == kept_q);
	assign status.out_free   = out_free;

	assign out_valid    = out_valid_q;
	assign sorted_value = sorted_q;
	assign last_of_run  = last_out_q;
	assign is_empty     = empty_q;
	assign had_drop     = drop_out_q;

endmodule

### design/pigeonhole_sorter.sv
// ----------------------------------------------------------------------------
// Pigeonhole sorter
// Counting sort of one set of signed 16-bit values per run.
// ----------------------------------------------------------------------------
// Values arrive on the input channel (in_valid/in_stall, value, is_last), one
// per transfer. A value inside [min_value, max_value] whose hole index fits the
// count memory, while fewer than MAX_ITEMS values are kept, bumps its hole
// count; any other value is dropped and flagged through had_drop.
// The count memory is read on the accept cycle and written back in the cycle
// after, while in_stall is high, so no transfer can follow straight on another.
// After the transfer with is_last, the controller walks the holes upward from
// hole zero: per hole a memory read (WALK_RD), then a check and clear
// (WALK_CHK), then one result per count (EMIT), stopping at the highest kept
// hole. Each hole is zeroed as it is read, so the memory is clean for the next
// set. An empty set gives a single result with is_empty set from the EMPTY state.
// Results leave through an output register (out_valid/out_stall); while the
// receiver stalls, the walk waits and the held result stays unchanged.
// After reset a clearing pass writes zero to every hole, one per cycle, and
// in_stall is high until it ends. The user must write the configuration port
// (cfg_we, cfg_index, cfg_data) only between runs; the block does not enforce it.
// ----------------------------------------------------------------------------
`include "pigeonhole_sorter_assert.svh"

module pigeonhole_sorter #(
	parameter int HOLES     = phs_pkg::PHS_HOLES,
	parameter int MAX_ITEMS = phs_pkg::PHS_MAX_ITEMS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [phs_pkg::IDX_W-1:0]        cfg_index,
	input  logic [phs_pkg::VAL_W-1:0]        cfg_data,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic signed [phs_pkg::VAL_W-1:0] value,
	input  logic                             is_last,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic signed [phs_pkg::VAL_W-1:0] sorted_value,
	output logic                             last_of_run,
	output logic                             is_empty,
	output logic                             had_drop
);

	import phs_pkg::*;

	phs_cmd_t    cmd;
	phs_status_t status;

	// All result fields side by side, for the hold check below.
	logic [VAL_W+2:0] out_word;

	// The controller only takes a transfer while idle; everything else stalls.
	assign in_stall = !cmd.idle;

	assign out_word = {sorted_value, last_of_run, is_empty, had_drop};

	phs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.status   (status),
		.cmd      (cmd)
	);

	phs_dp #(
		.HOLES     (HOLES),
		.MAX_ITEMS (MAX_ITEMS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.status       (status),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.value        (value),
		.is_last      (is_last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sorted_value (sorted_value),
		.last_of_run  (last_of_run),
		.is_empty     (is_empty),
		.had_drop     (had_drop)
	);

	// A last element always starts a run, so the input must be busy right after it.
	`PHS_ASSERT_NEXT(a_last_blocks_input, in_valid && !in_stall && is_last, in_stall, "input open after last")

	// A stalled result stays valid and none of its fields change.
	`PHS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_word), "held result changed")

	// No result may be loaded while an input transfer is being taken.
	`PHS_ASSERT_SAME(a_no_overlap, cmd.emit || cmd.empty, in_stall, "emission while input open")

endmodule

### test/pigeonhole_sorter_tb.sv
// ----------------------------------------------------------------------------
// Pigeonhole sorter testbench
// Sends sets of signed values to the sorter under several min/max windows and
// checks every sorted result, field by field, against a counting-sort model
// that is kept in step with each accepted input transfer.
// ----------------------------------------------------------------------------
module pigeonhole_sorter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import phs_pkg::*;

	// The walk ends with the last result of a set, so the block is back in idle
	// once that result is taken, before the window is rewritten.
	localparam int SETTLE_CYCLES = 8;
	localparam int SHOWN_ERRORS  = 10;

	typedef struct packed {
		logic signed [VAL_W-1:0] sorted_value;
		logic                    last_of_run;
		logic                    is_empty;
		logic                    had_drop;
	} sort_result_t;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_we = 1'b0;
	logic [IDX_W-1:0]        cfg_index = REG_MIN_VALUE;
	logic [VAL_W-1:0]        cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	logic signed [VAL_W-1:0] value = '0;
	logic                    is_last = 1'b0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	logic signed [VAL_W-1:0] sorted_value;
	logic                    last_of_run;
	logic                    is_empty;
	logic                    had_drop;

	pigeonhole_sorter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.value        (value),
		.is_last      (is_last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sorted_value (sorted_value),
		.last_of_run  (last_of_run),
		.is_empty     (is_empty),
		.had_drop     (had_drop)
	);

	// Model state: one tally per hole, the number of values kept so far, the
	// sticky drop flag of the current set, and the configured window.
	logic [CNT_W-1:0]        hole_tally [PHS_HOLES];
	logic [CNT_W-1:0]        kept_tally;
	logic                    drop_flag;
	logic signed [VAL_W-1:0] win_lo;
	logic signed [VAL_W-1:0] win_hi;

	// Sorted results still owed by the block, oldest first.
	sort_result_t sorted_runs [$];

	// While steady is set neither side idles, so transfers follow as fast as the block takes them.
	logic steady = 1'b0;

	int errors = 0;
	int items_sent = 0;
	int sets_sent = 0;
	int results_seen = 0;
	int windows_used = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Unless steady is set, the receiver stalls in roughly a quarter of the cycles.
	always @(negedge clk) begin
		out_stall <= !steady && ($urandom_range(99) < 23);
	end

	task automatic note_error(input string what);
		errors++;
		if (errors <= SHOWN_ERRORS)
			$display("[%0t] %s", $realtime, what);
	endtask

	// Appends one result to the tail of the owed list.
	function automatic void owe_result(input sort_result_t r);
		sorted_runs = {sorted_runs, r};
	endfunction

	// Counting-sort prediction for one accepted transfer. A value is kept only
	// when it lies inside the window, its hole fits the store and the set has
	// room left; anything else just raises the drop flag. The transfer marked
	// last closes the set: the holes are walked upward and every kept value is
	// queued as often as it was counted, or one empty result when none was kept.
	task automatic bin_and_sort(input logic signed [VAL_W-1:0] v, input logic last);
		int           lo;
		int           hi;
		int           vi;
		int           slot;
		int           n;
		sort_result_t res;

		lo = win_lo;
		hi = win_hi;
		vi = v;
		if (vi < lo || vi > hi) begin
			drop_flag = 1'b1;
		end else begin
			slot = vi - lo;
			if (slot >= PHS_HOLES || kept_tally >= PHS_MAX_ITEMS) begin
				drop_flag = 1'b1;
			end else begin
				hole_tally[slot]++;
				kept_tally++;
			end
		end
		if (!last)
			return;

		if (kept_tally == 0) begin
			res = '{sorted_value: '0, last_of_run: 1'b1, is_empty: 1'b1, had_drop: drop_flag};
			owe_result(res);
		end else begin
			n = 0;
			for (int h = 0; h < PHS_HOLES; h++) begin
				for (int c = 0; c < hole_tally[h]; c++) begin
					n++;
					res.sorted_value = VAL_W'(lo + h);
					res.last_of_run  = (n == kept_tally);
					res.is_empty     = 1'b0;
					res.had_drop     = drop_flag;
					owe_result(res);
				end
			end
		end
		foreach (hole_tally[h])
			hole_tally[h] = '0;
		kept_tally = '0;
		drop_flag  = 1'b0;
	endtask

	// Every result taken by the receiver is matched against the oldest one owed.
	always @(posedge clk) begin : check_results
		sort_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (sorted_runs.size() == 0) begin
				note_error($sformatf("unexpected result: value %0d last %0b empty %0b drop %0b",
					sorted_value, last_of_run, is_empty, had_drop));
			end else begin
				want = sorted_runs.pop_front();
				if (want.sorted_value !== sorted_value || want.last_of_run !== last_of_run ||
				    want.is_empty !== is_empty || want.had_drop !== had_drop)
					note_error($sformatf({"result mismatch: expected value %0d last %0b ",
						"empty %0b drop %0b, got value %0d last %0b empty %0b drop %0b"},
						want.sorted_value, want.last_of_run, want.is_empty, want.had_drop,
						sorted_value, last_of_run, is_empty, had_drop));
			end
		end
	end

	// Sends one value. It is entered and left at a falling edge; on return the
	// valid is still high, so the next call can keep it up without a glitch.
	task automatic send_item(input logic signed [VAL_W-1:0] v, input logic last);
		while (!steady && $urandom_range(99) < 23) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		value    <= v;
		is_last  <= last;
		do
			@(posedge clk);
		while (in_stall);
		bin_and_sort(v, last);
		items_sent++;
		if (last)
			sets_sent++;
		@(negedge clk);
	endtask

	// Drops valid, waits until every owed result has arrived and then lets the
	// block settle, so the block is idle afterwards.
	task automatic drain;
		in_valid <= 1'b0;
		while (sorted_runs.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Writes the minimum register, then the maximum one; only called while idle.
	task automatic set_window(input int lo, input int hi);
		cfg_we    <= 1'b1;
		cfg_index <= REG_MIN_VALUE;
		cfg_data  <= VAL_W'(lo);
		@(negedge clk);
		cfg_index <= REG_MAX_VALUE;
		cfg_data  <= VAL_W'(hi);
		@(negedge clk);
		cfg_we <= 1'b0;
		win_lo = VAL_W'(lo);
		win_hi = VAL_W'(hi);
		windows_used++;
	endtask

	function automatic int clamp16(input int x);
		if (x < -32768)
			return -32768;
		if (x > 32767)
			return 32767;
		return x;
	endfunction

	// Mostly values that land in a hole, with repeats to stack counts, plus
	// values just outside the window or the store and some plain noise.
	function automatic logic signed [VAL_W-1:0] pick_value(input logic signed [VAL_W-1:0] prev);
		int lo;
		int top;
		int roll;
		lo  = win_lo;
		top = win_hi;
		if (top > lo + PHS_HOLES - 1)
			top = lo + PHS_HOLES - 1;
		roll = $urandom_range(99);
		if (roll < 20)
			return prev;
		if (roll < 75 && lo <= top)
			return VAL_W'(lo + int'($urandom_range(top - lo)));
		if (roll < 88) begin
			case ($urandom_range(3))
				0: return VAL_W'(lo - 1);
				1: return VAL_W'(int'(win_hi) + 1);
				2: return VAL_W'(lo + PHS_HOLES);
				default: return VAL_W'(top);
			endcase
		end
		return VAL_W'($urandom);
	endfunction

	// Set sizes are mostly short; now and then one runs into the item limit.
	function automatic int set_length;
		int roll;
		roll = $urandom_range(99);
		if (roll < 85)
			return $urandom_range(12, 1);
		if (roll < 95)
			return $urandom_range(40, 13);
		return $urandom_range(70, 60);
	endfunction

	task automatic random_sets(input int target);
		int                      first;
		int                      len;
		logic signed [VAL_W-1:0] v;
		first = items_sent;
		v = win_lo;
		while (items_sent - first < target) begin
			len = set_length();
			for (int k = 0; k < len; k++) begin
				v = pick_value(v);
				send_item(v, k == len - 1);
			end
		end
	endtask

	// Reset window 0..255: both ends of the store, a repeated value, and
	// values just below and just above the window.
	task automatic test_default_window;
		send_item(16'sd255, 1'b0);
		send_item(16'sd0, 1'b0);
		send_item(16'sd7, 1'b0);
		send_item(16'sd7, 1'b0);
		send_item(-16'sd1, 1'b0);
		send_item(16'sd256, 1'b0);
		send_item(16'sd128, 1'b1);
		drain();
	endtask

	// A set with nothing kept gives a single empty result carrying the drop.
	task automatic test_empty_set;
		send_item(16'sd300, 1'b1);
		send_item(-16'sd5, 1'b0);
		send_item(16'sd1000, 1'b1);
		drain();
	endtask

	// Windows at both ends of the 16-bit range. With the full range open,
	// values past the last hole are dropped even though they are in bounds.
	task automatic test_extreme_windows;
		set_window(-32768, 32767);
		send_item(-16'sd32768, 1'b0);
		send_item(-16'sd32513, 1'b0);
		send_item(-16'sd32512, 1'b0);
		send_item(16'sd32767, 1'b0);
		send_item(-16'sd32768, 1'b1);
		drain();
		set_window(32512, 32767);
		send_item(16'sd32767, 1'b0);
		send_item(16'sd32512, 1'b0);
		send_item(-16'sd32768, 1'b0);
		send_item(16'sd32600, 1'b1);
		drain();
	endtask

	// Minimum above maximum keeps nothing; a single-hole window keeps only it.
	task automatic test_narrow_windows;
		set_window(100, 99);
		send_item(16'sd100, 1'b0);
		send_item(16'sd99, 1'b0);
		send_item(16'sd50, 1'b1);
		drain();
		set_window(-7, -7);
		send_item(-16'sd7, 1'b0);
		send_item(-16'sd8, 1'b0);
		send_item(-16'sd7, 1'b1);
		drain();
	endtask

	// Exactly the item limit with no drop, one hole filled past the limit,
	// and a long random set that overruns it.
	task automatic test_item_limit;
		logic signed [VAL_W-1:0] v;
		set_window(-100, 155);
		for (int k = 0; k < PHS_MAX_ITEMS; k++)
			send_item(VAL_W'(int'($urandom_range(255)) - 100), k == PHS_MAX_ITEMS - 1);
		for (int k = 0; k < PHS_MAX_ITEMS + 2; k++)
			send_item(16'sd3, k == PHS_MAX_ITEMS + 1);
		v = win_lo;
		for (int k = 0; k < 70; k++) begin
			v = pick_value(v);
			send_item(v, k == 69);
		end
		drain();
	endtask

	// Random sets under a series of windows: fixed ones first (both ends, the full range,
	// a single hole and an inverted one), then four drawn at random across the whole value range.
	task automatic test_random_windows;
		int lo;
		set_window(-32768, -32513);
		random_sets(20);
		drain();
		set_window(32512, 32767);
		random_sets(20);
		drain();
		set_window(-32768, 32767);
		random_sets(20);
		drain();
		set_window(-20, -20);
		random_sets(15);
		drain();
		set_window(500, 400);
		random_sets(15);
		drain();
		for (int w = 0; w < 4; w++) begin
			lo = int'($urandom_range(65535)) - 32768;
			if ($urandom_range(3) == 0)
				set_window(lo, int'($urandom_range(65535)) - 32768);
			else
				set_window(lo, clamp16(lo + int'($urandom_range(400))));
			random_sets(20);
			drain();
		end
	endtask

	// A long stretch with neither side idling, so transfers go as fast as the block takes them.
	task automatic test_back_to_back;
		set_window(-64, 191);
		steady = 1'b1;
		random_sets(60);
		drain();
		steady = 1'b0;
	endtask

	initial begin
		foreach (hole_tally[h])
			hole_tally[h] = '0;
		kept_tally = '0;
		drop_flag  = 1'b0;
		win_lo     = 16'sd0;
		win_hi     = 16'sd255;

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		// The clearing pass after reset holds in_stall high until it is done.
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);

		test_default_window();
		test_empty_set();
		test_extreme_windows();
		test_narrow_windows();
		test_item_limit();
		test_random_windows();
		test_back_to_back();

		if (sorted_runs.size() != 0)
			note_error($sformatf("%0d expected results never arrived", sorted_runs.size()));
		$display("Sorted %0d sets (%0d values, %0d results checked) under %0d windows.",
			sets_sent, items_sent, results_seen, windows_used);
		$display("Windows covered both ends of the value range, a single hole and an inverted one.");
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("%0d errors", errors);
			$display("FAIL");
		end
		$finish;
	end

	// Watchdog: far beyond any correct run.
	initial begin
		#4_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
